/* hdl/oosq_pkg.sv */
// Shared types and codes for the oldest-or-richest server queue.
// Used by oosq_ctrl, oosq_dpath and the top level; depends on nothing.
package oosq_pkg;

   // Kind of request carried on req_tuser.
   localparam logic [1:0] FUNC_ARRIVE  = 2'd0;
   localparam logic [1:0] FUNC_OLDEST  = 2'd1;
   localparam logic [1:0] FUNC_RICHEST = 2'd2;

   // Result status carried on rsp_tuser.
   localparam logic [1:0] STAT_STORED = 2'd0;
   localparam logic [1:0] STAT_SERVED = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;
   localparam logic [1:0] STAT_EMPTY  = 2'd3;

   localparam int CUST_BITS = 32;

   typedef enum logic [2:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_SCAN,
      CTL_LAST,
      CTL_COMMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic op_load;
      logic clr_wr;
      logic scan_rd;
      logic commit;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic rsp_free;
   } dp_stat_type;

endpackage

/* hdl/oosq_dpath.sv */
// Datapath of the server queue: slot memory, scan compare, sequence counter
// and the result register. Depends on oosq_pkg; driven by oosq_ctrl.
module oosq_dpath
   import oosq_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int AMOUNT_BITS   = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  ctl_cmd_type   cmd,
   output dp_stat_type   stat,
   input  logic [1:0]    func,
   input  logic [19:0]   amount,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [1:0]    rsp_status,
   output logic [31:0]   rsp_customer
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   typedef struct packed {
      logic                   valid;
      logic [CUST_BITS-1:0]   cust;
      logic [AMOUNT_BITS-1:0] amt;
   } entry_type;

   entry_type              mem [TABLE_ENTRIES];

   logic [1:0]             op_func_ff;
   logic [AMOUNT_BITS-1:0] op_amt_ff, op_amt_in;
   logic [IDX_W-1:0]       cnt_ff;
   logic                   rd_pend_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   entry_type              rd_data_ff;
   logic                   found_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic [CUST_BITS-1:0]   best_cust_ff;
   logic [AMOUNT_BITS-1:0] best_amt_ff;
   logic [CUST_BITS-1:0]   next_cust_ff;
   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [CUST_BITS-1:0]   rsp_cust_ff, rsp_cust_in;

   logic [31:0]            amt_wide;
   logic                   is_arrive, by_amount, better, take;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;

   assign amt_wide  = 32'(amount);
   assign op_amt_in = amt_wide[AMOUNT_BITS-1:0];

   assign is_arrive = (op_func_ff == FUNC_ARRIVE);
   // The unused fourth code decodes as serve richest.
   assign by_amount = (op_func_ff != FUNC_ARRIVE) && (op_func_ff != FUNC_OLDEST);

   always_comb begin
      if (by_amount) begin
         better = (rd_data_ff.amt > best_amt_ff) ||
                  ((rd_data_ff.amt == best_amt_ff) && (rd_data_ff.cust < best_cust_ff));
      end else begin
         better = (rd_data_ff.cust < best_cust_ff);
      end
      if (is_arrive) begin
         take = rd_pend_ff && !found_ff && !rd_data_ff.valid;
      end else begin
         take = rd_pend_ff && rd_data_ff.valid && (!found_ff || better);
      end
   end

   // Result of the finished scan.
   always_comb begin
      rsp_status_in = STAT_EMPTY;
      rsp_cust_in   = '0;
      if (is_arrive) begin
         rsp_status_in = found_ff ? STAT_STORED : STAT_FULL;
         rsp_cust_in   = found_ff ? next_cust_ff : '0;
      end else if (found_ff) begin
         rsp_status_in = STAT_SERVED;
         rsp_cust_in   = best_cust_ff;
      end
   end

   // One memory write port: clearing pass, store on arrive, release on serve.
   always_comb begin
      wr_en   = cmd.clr_wr || (cmd.commit && found_ff);
      wr_addr = cmd.clr_wr ? cnt_ff : best_idx_ff;
      if (cmd.clr_wr) begin
         wr_data = '{valid: 1'b0, cust: best_cust_ff, amt: best_amt_ff};
      end else if (is_arrive) begin
         wr_data = '{valid: 1'b1, cust: next_cust_ff, amt: op_amt_ff};
      end else begin
         wr_data = '{valid: 1'b0, cust: best_cust_ff, amt: best_amt_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= mem[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         found_ff     <= 1'b0;
         next_cust_ff <= CUST_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.scan_rd;
         if (cmd.op_load) begin
            cnt_ff   <= '0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.clr_wr || cmd.scan_rd) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.commit && found_ff && is_arrive) begin
            next_cust_ff <= next_cust_ff + 1'b1;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op_load) begin
         op_func_ff <= func;
         op_amt_ff  <= op_amt_in;
      end
      rd_idx_ff <= cnt_ff;
      if (take) begin
         best_idx_ff  <= rd_idx_ff;
         best_cust_ff <= rd_data_ff.cust;
         best_amt_ff  <= rd_data_ff.amt;
      end
      if (cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_cust_ff   <= rsp_cust_in;
      end
   end

   assign stat.scan_last = (cnt_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_customer = rsp_cust_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (next_cust_ff != $past(next_cust_ff)))
         |-> (rsp_valid_ff && (rsp_status_ff == STAT_STORED)))
      else $error("sequence number advanced without a stored result");

   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_wr && (cmd.scan_rd || cmd.commit)))
      else $error("clearing pass overlaps a scan or commit");

endmodule

/* hdl/oosq_ctrl.sv */
// Controller state machine of the server queue: clearing pass, scan and
// commit sequencing. Depends on oosq_pkg; drives oosq_dpath.
module oosq_ctrl
   import oosq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_CLEAR:  if (stat.scan_last) state_in = CTL_IDLE;
         CTL_IDLE:   if (req_tvalid) state_in = CTL_SCAN;
         CTL_SCAN:   if (stat.scan_last) state_in = CTL_LAST;
         CTL_LAST:   state_in = CTL_COMMIT;
         CTL_COMMIT: if (stat.rsp_free) state_in = CTL_IDLE;
         default:    state_in = CTL_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         CTL_CLEAR:  cmd.clr_wr = 1'b1;
         CTL_IDLE: begin
            req_tready  = 1'b1;
            cmd.op_load = req_tvalid;
         end
         CTL_SCAN:   cmd.scan_rd = 1'b1;
         CTL_LAST:   cmd = '0;
         CTL_COMMIT: cmd.commit = stat.rsp_free;
         default:    cmd = '0;
      endcase
   end

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat accepted while an item is in work");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_wr |-> !req_tready)
      else $error("beat accepted during the clearing pass");

   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_rd && stat.scan_last) |=> !cmd.scan_rd)
      else $error("scan ran past the last slot");

endmodule

/* hdl/oldest_or_richest_server_queue.sv */
// Top level of the oldest-or-richest server queue: controller plus datapath.
// Depends on oosq_pkg, oosq_ctrl and oosq_dpath.
//
//   Channel   Dir  Handshake            Payload
//   req_      in   req_tvalid/tready    tuser[1:0] func, tdata[19:0] amount
//   rsp_      out  rsp_tvalid/tready    tuser[1:0] status, tdata[31:0] customer
//
// Every item walks the whole slot table once: the single read port of the slot
// memory delivers one slot per cycle, so an item passes through accept, scan,
// final compare and commit, and its result is loaded at the commit; the next
// beat can be accepted in the cycle after the commit.
// After reset a clearing pass marks every slot free;
// req_tready stays low during it.
// The result sits in an output register, so a new item is accepted and scanned
// while the previous result waits; only the commit waits for rsp_tready.
// Arrive takes the lowest free slot; serve oldest picks the smallest sequence
// number and serve richest the largest amount, ties to the smaller sequence
// number and then to the lower slot. Sequence numbers start at one and wrap.
module oldest_or_richest_server_queue
   import oosq_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int AMOUNT_BITS   = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [19:0] amount, [23:20] zero fill
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] customer
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   oosq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   oosq_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .AMOUNT_BITS   (AMOUNT_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .func         (req_tuser),
      .amount       (req_tdata[19:0]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_status   (rsp_tuser),
      .rsp_customer (rsp_tdata)
   );

endmodule

/* dv/tb.sv */
// Self-checking testbench for oldest_or_richest_server_queue.
// It drives request beats and predicts each response with its own copy of the slot table.
// Depends on oosq_pkg and the block under test; nothing else is read.
module tb;
   import oosq_pkg::*;

   localparam int TABLE_SLOTS = 64;
   localparam int AMT_BITS    = 20;
   // The fourth func code has no name in the package; the block treats it as serve richest.
   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam int RANDOM_PER_PHASE = 430;
   localparam int SETTLE_CYCLES    = TABLE_SLOTS + 40;

   typedef struct packed {
      logic [1:0]          func;
      logic [AMT_BITS-1:0] amount;
   } request_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [CUST_BITS-1:0] customer;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // [19:0] amount, [23:20] zero fill
   logic [1:0]  req_tuser = '0;    // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] customer
   logic [1:0]  rsp_tuser;         // [1:0] status

   request_type waiting_reqs[$];
   outcome_type due_outcomes[$];
   int          send_idle_pct = 26;
   int          recv_idle_pct = 60;
   int          mismatches = 0;
   int          fill_guess = 0;
   bit          req_taken = 1'b0;

   // Shadow copy of the slot table and the sequence counter.
   bit                   slot_used[TABLE_SLOTS];
   logic [CUST_BITS-1:0] slot_seq[TABLE_SLOTS];
   logic [AMT_BITS-1:0]  slot_amt[TABLE_SLOTS];
   logic [CUST_BITS-1:0] next_seq = CUST_BITS'(1);

   oldest_or_richest_server_queue #(
      .TABLE_ENTRIES(TABLE_SLOTS),
      .AMOUNT_BITS  (AMT_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Applies one accepted request to the shadow table and queues the response it must cause.
   task automatic apply_to_table(input logic [1:0] func, input logic [AMT_BITS-1:0] amount);
      outcome_type got;
      int          pick;
      bit          by_amount;
      got.status   = STAT_STORED;
      got.customer = '0;
      pick = -1;
      if (func == FUNC_ARRIVE) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (!slot_used[i] && pick < 0) pick = i;
         end
         if (pick < 0) begin
            got.status = STAT_FULL;
         end else begin
            slot_used[pick] = 1'b1;
            slot_seq[pick]  = next_seq;
            slot_amt[pick]  = amount;
            got.customer    = next_seq;
            next_seq        = next_seq + 1'b1;
         end
      end else begin
         by_amount = (func != FUNC_OLDEST);
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_used[i]) begin
               if (pick < 0) begin
                  pick = i;
               end else if (by_amount) begin
                  if (slot_amt[i] > slot_amt[pick] ||
                      (slot_amt[i] == slot_amt[pick] && slot_seq[i] < slot_seq[pick]))
                     pick = i;
               end else if (slot_seq[i] < slot_seq[pick]) begin
                  pick = i;
               end
            end
         end
         if (pick < 0) begin
            got.status = STAT_EMPTY;
         end else begin
            got.status      = STAT_SERVED;
            got.customer    = slot_seq[pick];
            slot_used[pick] = 1'b0;
         end
      end
      due_outcomes.insert(due_outcomes.size(), got);
   endtask

   // Queues a request and keeps a rough count of occupied slots to steer the random mix.
   task automatic push_req(input logic [1:0] func, input logic [AMT_BITS-1:0] amount);
      request_type item;
      item.func   = func;
      item.amount = amount;
      waiting_reqs.insert(waiting_reqs.size(), item);
      if (func == FUNC_ARRIVE) begin
         if (fill_guess < TABLE_SLOTS) fill_guess++;
      end else if (fill_guess > 0) begin
         fill_guess--;
      end
   endtask

   function automatic logic [AMT_BITS-1:0] pick_amount();
      case ($urandom_range(9, 0))
         0:       return '0;
         1:       return '1;
         2, 3:    return AMT_BITS'($urandom_range(7, 0));   // narrow range forces ties
         default: return AMT_BITS'($urandom());
      endcase
   endfunction

   function automatic logic [1:0] pick_serve();
      int r;
      r = $urandom_range(9, 0);
      if (r == 0) return FUNC_SPARE;
      if (r < 5) return FUNC_OLDEST;
      return FUNC_RICHEST;
   endfunction

   // Random requests in episodes: fill to full and beyond, drain to empty and beyond,
   // or a mix leaning toward arrivals or serves.
   task automatic make_random(input int count);
      int made;
      int n;
      int arrive_pct;
      made = 0;
      while (made < count) begin
         case ($urandom_range(3, 0))
            0: begin
               n = TABLE_SLOTS - fill_guess + $urandom_range(4, 0);
               arrive_pct = 100;
            end
            1: begin
               n = fill_guess + $urandom_range(3, 0);
               arrive_pct = 0;
            end
            default: begin
               n = $urandom_range(40, 10);
               arrive_pct = $urandom_range(1, 0) ? 70 : 30;
            end
         endcase
         for (int k = 0; k < n && made < count; k++) begin
            if ($urandom_range(99, 0) < arrive_pct) push_req(FUNC_ARRIVE, pick_amount());
            else push_req(pick_serve(), AMT_BITS'($urandom()));
            made++;
         end
      end
   endtask

   task automatic wait_drained();
      while (waiting_reqs.size() != 0 || due_outcomes.size() != 0 || req_tvalid)
         @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input outcome_type want);
      mismatches++;
      if (mismatches <= 10)
         $display({"mismatch (%s): expected status %0d customer %0d, ",
                   "got status %0d customer %0d"},
                  what, want.status, want.customer, rsp_tuser, rsp_tdata);
   endtask

   // Request acceptance: sampled at the rising edge, prediction made right away.
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         apply_to_table(req_tuser, req_tdata[AMT_BITS-1:0]);
         req_taken = 1'b1;
      end
   end

   // Request driver: presents the next queued beat at the falling edge, with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (waiting_reqs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser  <= waiting_reqs[0].func;
            req_tdata  <= {4'b0, waiting_reqs[0].amount};
            waiting_reqs.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side: random back-pressure, checked against the oldest prediction.
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99, 0) >= recv_idle_pct);
   end

   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_outcomes.size() == 0) begin
            want = '0;
            report_mismatch("no beat expected", want);
         end else begin
            want = due_outcomes.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata !== want.customer)
               report_mismatch("wrong field", want);
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: serves on an empty table, extreme amounts, ties on amount,
      // the spare func code, and an oldest serve after richest serves.
      push_req(FUNC_OLDEST, '0);
      push_req(FUNC_RICHEST, '1);
      push_req(FUNC_SPARE, '0);
      push_req(FUNC_ARRIVE, '0);
      push_req(FUNC_ARRIVE, '1);
      push_req(FUNC_ARRIVE, '1);
      push_req(FUNC_ARRIVE, 20'd5);
      push_req(FUNC_ARRIVE, '0);
      push_req(FUNC_RICHEST, '0);
      push_req(FUNC_SPARE, '1);
      push_req(FUNC_OLDEST, 20'h5A5A5);
      push_req(FUNC_OLDEST, '0);
      push_req(FUNC_RICHEST, '0);
      push_req(FUNC_ARRIVE, 20'h80000);
      push_req(FUNC_ARRIVE, 20'h7FFFF);
      push_req(FUNC_SPARE, '0);
      push_req(FUNC_OLDEST, '0);
      push_req(FUNC_OLDEST, '0);

      // Phase one: sender idles often, receiver more so.
      make_random(RANDOM_PER_PHASE);
      wait_drained();

      // Phase two: the idle rates swap sides.
      send_idle_pct = 60;
      recv_idle_pct = 26;
      make_random(RANDOM_PER_PHASE);
      wait_drained();

      // Phase three: both sides run flat out.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      make_random(RANDOM_PER_PHASE);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_outcomes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #1500000;
      $display("tb: failure");
      $finish;
   end

endmodule
